### sv/sha1_hash_engine_macros.svh
// Assertion macros shared by the SHA-1 hash engine RTL.
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define SHA1HE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define SHA1HE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sha1he_pkg.sv
// Shared types and constants of the SHA-1 hash engine.
`default_nettype none

package sha1he_pkg;

    localparam int unsigned ROUNDS = 80;

    // The five round variables, also used for the five chaining words.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } sha1he_vars_t;

    localparam sha1he_vars_t INIT_CHAIN = '{
        a: 32'h6745_2301,
        b: 32'hefcd_ab89,
        c: 32'h98ba_dcfe,
        d: 32'h1032_5476,
        e: 32'hc3d2_e1f0
    };

    localparam logic [31:0] K_0 = 32'h5a82_7999;
    localparam logic [31:0] K_1 = 32'h6ed9_eba1;
    localparam logic [31:0] K_2 = 32'h8f1b_bcdc;
    localparam logic [31:0] K_3 = 32'hca62_c1d6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } sha1he_state_t;

endpackage

`default_nettype wire

### sv/sha1he_round.sv
// One SHA-1 round and one message schedule step, shared by all 80 rounds.
`default_nettype none

module sha1he_round (
    input  var sha1he_pkg::sha1he_vars_t vars,
    input  wire logic [6:0]              round,
    input  wire logic [31:0]             w0,
    input  wire logic [31:0]             w2,
    input  wire logic [31:0]             w8,
    input  wire logic [31:0]             w13,
    output sha1he_pkg::sha1he_vars_t     vars_next,
    output logic [31:0]                  w_new
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] w_mix;

    // Round function and constant change every twenty rounds.
    always_comb
    begin
        if (round < 7'd20)
        begin
            f = (vars.b & vars.c) | (~vars.b & vars.d);
            k = sha1he_pkg::K_0;
        end
        else if (round < 7'd40)
        begin
            f = vars.b ^ vars.c ^ vars.d;
            k = sha1he_pkg::K_1;
        end
        else if (round < 7'd60)
        begin
            f = (vars.b & vars.c) | (vars.b & vars.d) | (vars.c & vars.d);
            k = sha1he_pkg::K_2;
        end
        else
        begin
            f = vars.b ^ vars.c ^ vars.d;
            k = sha1he_pkg::K_3;
        end
    end

    assign vars_next.a = {vars.a[26:0], vars.a[31:27]} + f + vars.e + k + w0;
    assign vars_next.b = vars.a;
    assign vars_next.c = {vars.b[1:0], vars.b[31:2]};
    assign vars_next.d = vars.c;
    assign vars_next.e = vars.d;

    // Schedule word sixteen places ahead of the one used in this round.
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

endmodule

`default_nettype wire

### sv/sha1_hash_engine.sv
// SHA-1 hash engine: byte stream in, five-word digest out.
//
// The engine hashes a message delivered one byte per input transfer. A
// transfer with tuser high carries a byte in tdata[7:0]; tlast ends the
// message, after the byte if both are set, and a transfer with tlast and no
// byte ends the message as it stands (alone, the empty message). A transfer
// with neither does nothing. A byte that does not complete a 64-byte block
// is taken and the engine is ready again at once. A byte that completes a
// block starts the compression: 80 rounds at one round per cycle in a
// single shared round unit, then the add into the chaining words, with
// tready low throughout. On the last transfer the engine writes the 0x80
// marker, compresses once more if 56 or more bytes of the final block are
// used, writes the 64-bit bit length and compresses the final block, then
// offers the digest as five output transfers, word 0 (most significant)
// first, with tuser giving the word index and tlast marking word 4. The
// round unit sets the pace: one round per clock cycle. While the digest is
// being offered no input is taken; after word 4 has been transferred the
// engine is back in its reset state, ready for the next message. The byte
// count is 61 bits and wraps, so the length field is that count times eight.
`default_nettype none

`include "sha1_hash_engine_macros.svh"

module sha1_hash_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // is_last
    // Digest stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // last_word
);

    sha1he_pkg::sha1he_state_t state_reg;
    sha1he_pkg::sha1he_state_t state_next;
    // State to resume once a compression has finished.
    sha1he_pkg::sha1he_state_t ret_reg;

    sha1he_pkg::sha1he_vars_t  chain_reg;
    sha1he_pkg::sha1he_vars_t  vars_reg;
    sha1he_pkg::sha1he_vars_t  vars_rnd;

    // Sixteen-word window of the message schedule. During a compression it
    // shifts towards word 0 each round, so word 0 is always the word in use.
    logic [31:0] win_reg [16];
    logic [31:0] w_new;

    logic [60:0] count_reg;
    logic [60:0] count_inc;
    logic [5:0]  pos;
    logic [6:0]  round_reg;
    logic [2:0]  out_idx_reg;

    logic        in_xfer;
    logic        out_xfer;
    logic        block_full;
    logic [31:0] data_lane;
    logic [31:0] pad_lane;
    logic [63:0] bit_len;

    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign out_xfer   = m_axis_tvalid && m_axis_tready;
    assign count_inc  = count_reg + 61'd1;
    assign pos        = count_reg[5:0];
    assign block_full = (count_inc[5:0] == 6'd0);
    assign bit_len    = {count_reg, 3'b000};

    // Bytes are packed big-endian: position 0 of a word is its top byte.
    assign data_lane = {24'd0, s_axis_tdata} << {~pos[1:0], 3'b000};
    assign pad_lane  = {24'd0, sha1he_pkg::PAD_BYTE} << {~pos[1:0], 3'b000};

    sha1he_round u_round (
        .vars      (vars_reg),
        .round     (round_reg),
        .w0        (win_reg[0]),
        .w2        (win_reg[2]),
        .w8        (win_reg[8]),
        .w13       (win_reg[13]),
        .vars_next (vars_rnd),
        .w_new     (w_new)
    );

    // Sequencer: next state and handshake outputs.
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (state_reg)
            sha1he_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser && block_full)
                    begin
                        state_next = sha1he_pkg::ST_ROUND;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = sha1he_pkg::ST_PAD;
                    end
                end
            end
            sha1he_pkg::ST_ROUND:
            begin
                if (round_reg == 7'(sha1he_pkg::ROUNDS - 1))
                begin
                    state_next = sha1he_pkg::ST_ADD;
                end
            end
            sha1he_pkg::ST_ADD:
            begin
                state_next = ret_reg;
            end
            sha1he_pkg::ST_PAD:
            begin
                state_next = (pos >= 6'd56) ? sha1he_pkg::ST_ROUND : sha1he_pkg::ST_LEN;
            end
            sha1he_pkg::ST_LEN:
            begin
                state_next = sha1he_pkg::ST_ROUND;
            end
            sha1he_pkg::ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready && (out_idx_reg == 3'd4))
                begin
                    state_next = sha1he_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha1he_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1he_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Chaining words, schedule window, byte count and sequencing counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg   <= sha1he_pkg::INIT_CHAIN;
            count_reg   <= '0;
            round_reg   <= '0;
            out_idx_reg <= '0;
            ret_reg     <= sha1he_pkg::ST_IDLE;
            for (int i = 0; i < 16; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                sha1he_pkg::ST_IDLE:
                begin
                    if (in_xfer && s_axis_tuser)
                    begin
                        win_reg[pos[5:2]] <= win_reg[pos[5:2]] | data_lane;
                        count_reg         <= count_inc;
                        round_reg         <= '0;
                        ret_reg           <= s_axis_tlast ? sha1he_pkg::ST_PAD
                                                          : sha1he_pkg::ST_IDLE;
                    end
                end
                sha1he_pkg::ST_ROUND:
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        win_reg[i] <= win_reg[i + 1];
                    end
                    win_reg[15] <= w_new;
                    round_reg   <= round_reg + 7'd1;
                end
                sha1he_pkg::ST_ADD:
                begin
                    chain_reg.a <= chain_reg.a + vars_reg.a;
                    chain_reg.b <= chain_reg.b + vars_reg.b;
                    chain_reg.c <= chain_reg.c + vars_reg.c;
                    chain_reg.d <= chain_reg.d + vars_reg.d;
                    chain_reg.e <= chain_reg.e + vars_reg.e;
                    for (int i = 0; i < 16; i++)
                    begin
                        win_reg[i] <= '0;
                    end
                end
                sha1he_pkg::ST_PAD:
                begin
                    win_reg[pos[5:2]] <= win_reg[pos[5:2]] | pad_lane;
                    round_reg         <= '0;
                    ret_reg           <= sha1he_pkg::ST_LEN;
                end
                sha1he_pkg::ST_LEN:
                begin
                    win_reg[14] <= bit_len[63:32];
                    win_reg[15] <= bit_len[31:0];
                    round_reg   <= '0;
                    out_idx_reg <= '0;
                    ret_reg     <= sha1he_pkg::ST_OUT;
                end
                sha1he_pkg::ST_OUT:
                begin
                    if (out_xfer)
                    begin
                        if (out_idx_reg == 3'd4)
                        begin
                            chain_reg   <= sha1he_pkg::INIT_CHAIN;
                            count_reg   <= '0;
                            out_idx_reg <= '0;
                        end
                        else
                        begin
                            out_idx_reg <= out_idx_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    round_reg <= '0;
                end
            endcase
        end
    end

    // Round variables: loaded from the chaining words whenever a
    // compression is about to start, then advanced once per round.
    always_ff @(posedge clk)
    begin
        if (state_reg == sha1he_pkg::ST_ROUND)
        begin
            vars_reg <= vars_rnd;
        end
        else if (state_next == sha1he_pkg::ST_ROUND)
        begin
            vars_reg <= chain_reg;
        end
    end

    // Digest word selection.
    always_comb
    begin
        case (out_idx_reg)
            3'd0:    m_axis_tdata = chain_reg.a;
            3'd1:    m_axis_tdata = chain_reg.b;
            3'd2:    m_axis_tdata = chain_reg.c;
            3'd3:    m_axis_tdata = chain_reg.d;
            default: m_axis_tdata = chain_reg.e;
        endcase
    end

    assign m_axis_tuser = out_idx_reg;
    assign m_axis_tlast = (out_idx_reg == 3'd4);

    // The engine never takes input while a digest is on offer.
    `SHA1HE_ASSERT_IMP(a_no_overlap, s_axis_tready, !m_axis_tvalid,
        "input ready while digest is offered")
    // The digest word index stays within the five chaining words.
    `SHA1HE_ASSERT_IMP(a_idx_range, m_axis_tvalid, out_idx_reg <= 3'd4,
        "digest word index out of range")
    // The last round is always followed by the add into the chaining words.
    `SHA1HE_ASSERT_NXT(a_round_end,
        (state_reg == sha1he_pkg::ST_ROUND) && (round_reg == 7'(sha1he_pkg::ROUNDS - 1)),
        state_reg == sha1he_pkg::ST_ADD,
        "compression did not end after the last round")
    // After the final digest word the engine is back at its reset state.
    `SHA1HE_ASSERT_NXT(a_restart, out_xfer && m_axis_tlast,
        (state_reg == sha1he_pkg::ST_IDLE) && (count_reg == 61'd0),
        "engine not restored after digest")

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the SHA-1 hash engine: random byte streams against a digest predictor.
module testbench;

    // One input transfer as the driver offers it. A held item is not offered
    // until every digest word already predicted has been transferred.
    typedef struct {
        logic [7:0] data;
        bit         has;
        bit         last;
        bit         hold;
    } msg_item_t;

    // One predicted digest word.
    typedef struct {
        logic [31:0] word;
        logic [2:0]  position;
        bit          last;
    } digest_word_t;

    localparam int unsigned RANDOM_ITEMS   = 460;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES  = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Items still to be offered, and digest words still to be received.
    msg_item_t    byte_stream [$];
    digest_word_t digest_expect [$];

    // The predictor's own copy of the engine state.
    sha1he_pkg::sha1he_vars_t chain_words = sha1he_pkg::INIT_CHAIN;
    logic [31:0]  block_buf [16] = '{default: '0};
    logic [60:0]  msg_bytes = '0;

    msg_item_t   next_item;
    bit          byte_taken = 1'b0;
    bit          failed = 1'b0;
    bit          calm = 1'b0;
    int unsigned calm_left = 200;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int unsigned quiet_cycles = 0;
    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned counted_items = 0;

    sha1_hash_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Digest predictor
    // ------------------------------------------------------------------

    // One 80-round compression of block_buf into the chaining words. The
    // schedule is expanded in place over the sixteen-word window.
    function automatic void sha1_compress();
        logic [31:0] a, b, c, d, e, f, k, w, t;
        int unsigned slot;
        a = chain_words.a;
        b = chain_words.b;
        c = chain_words.c;
        d = chain_words.d;
        e = chain_words.e;
        for (int unsigned r = 0; r < sha1he_pkg::ROUNDS; r++)
        begin
            slot = r % 16;
            if (r >= 16)
            begin
                w = block_buf[(r + 13) % 16] ^ block_buf[(r + 8) % 16]
                  ^ block_buf[(r + 2) % 16] ^ block_buf[slot];
                block_buf[slot] = {w[30:0], w[31]};
            end
            w = block_buf[slot];
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1he_pkg::K_0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1he_pkg::K_1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1he_pkg::K_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1he_pkg::K_3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_words.a += a;
        chain_words.b += b;
        chain_words.c += c;
        chain_words.d += d;
        chain_words.e += e;
        block_buf = '{default: '0};
    endfunction

    // Bytes are packed big-endian: byte 0 of a word sits in its top bits.
    function automatic void place_byte(input int unsigned pos, input logic [7:0] value);
        block_buf[pos / 4][8 * (3 - pos % 4) +: 8] |= value;
    endfunction

    // Takes one accepted input transfer into the running hash and, at the end
    // of a message, queues the five digest words it must produce.
    function automatic void absorb_item(input logic [7:0] data, input bit has,
                                        input bit last);
        int unsigned pos;
        logic [63:0] bit_len;
        logic [31:0] words [5];
        if (has)
        begin
            place_byte(msg_bytes[5:0], data);
            msg_bytes = msg_bytes + 1'b1;
            if (msg_bytes[5:0] == 6'd0)
                sha1_compress();
        end
        if (last)
        begin
            // The marker byte goes first; if the length no longer fits, the
            // block is closed and the length goes into a fresh one.
            pos = msg_bytes[5:0];
            place_byte(pos, sha1he_pkg::PAD_BYTE);
            if (pos >= 56)
                sha1_compress();
            bit_len = {msg_bytes, 3'b000};
            block_buf[14] = bit_len[63:32];
            block_buf[15] = bit_len[31:0];
            sha1_compress();
            words = '{chain_words.a, chain_words.b, chain_words.c, chain_words.d,
                      chain_words.e};
            for (int i = 0; i < 5; i++)
                digest_expect.push_back('{word: words[i], position: 3'(i), last: (i == 4)});
            chain_words = sha1he_pkg::INIT_CHAIN;
            block_buf = '{default: '0};
            msg_bytes = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back, now and then a short pause, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    task automatic push_item(input logic [7:0] data, input bit has, input bit last,
                             input bit hold);
        byte_stream.push_back('{data: data, has: has, last: last, hold: hold});
        items_queued++;
        if (has || last)
            counted_items++;
    endtask

    // A whole message of random bytes. The end either rides on the final
    // byte or follows as a transfer of its own; now and then an ignored
    // transfer is slipped in between the bytes.
    task automatic queue_message(input int unsigned len, input bit hold);
        bit tail_byte;
        tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, hold);
                hold = 1'b0;
            end
            push_item(8'($urandom_range(0, 255)), 1'b1, tail_byte && (i == len - 1), hold);
            hold = 1'b0;
        end
        if (!tail_byte)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, hold);
    endtask

    // Lengths cluster round the padding boundaries: 55/56 bytes decide
    // whether the length needs an extra block, 64 fills a block exactly.
    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return $urandom_range(0, 3);
        else if (roll < 35)
            return $urandom_range(54, 57);
        else if (roll < 50)
            return $urandom_range(62, 66);
        else if (roll < 58)
            return $urandom_range(118, 122);
        return $urandom_range(4, 40);
    endfunction

    // ------------------------------------------------------------------
    // Pacing: calm stretches switch all idling off on both sides for a while.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (calm_left == 0)
        begin
            calm <= !calm;
            calm_left <= calm ? $urandom_range(100, 400) : $urandom_range(30, 150);
        end
        else
        begin
            calm_left <= calm_left - 1;
        end
    end

    // Input driver. A new item is offered only once the current one has been
    // transferred (or nothing is on offer), so tvalid never drops under a
    // pending item. Everything changes on the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || byte_taken)
        begin
            if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (byte_stream.size() > 0 &&
                     (!byte_stream[0].hold || digest_expect.size() == 0))
            begin
                next_item = byte_stream.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= next_item.data;
                s_axis_tuser <= next_item.has;
                s_axis_tlast <= next_item.last;
                send_gap <= calm ? 0 : pick_gap();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Digest receiver: tready is withheld for random stretches.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (recv_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            recv_stall <= recv_stall - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            recv_stall <= calm ? 0 : pick_gap();
        end
    end

    // Monitor: both sides are sampled on the rising edge. The digest side is
    // looked at first, so a word can never be matched against an expectation
    // raised by an input transfer at the same edge.
    always @(posedge clk)
    begin
        digest_word_t exp_word;
        byte_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_expect.size() == 0)
            begin
                $display("%0t: unexpected digest transfer: word %h index %0d last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                failed = 1'b1;
            end
            else
            begin
                exp_word = digest_expect.pop_front();
                if (m_axis_tdata !== exp_word.word)
                begin
                    $display("%0t: digest_word mismatch: expected %h, actual %h",
                             $time, exp_word.word, m_axis_tdata);
                    failed = 1'b1;
                end
                if (m_axis_tuser !== exp_word.position)
                begin
                    $display("%0t: word_index mismatch: expected %0d, actual %0d",
                             $time, exp_word.position, m_axis_tuser);
                    failed = 1'b1;
                end
                if (m_axis_tlast !== exp_word.last)
                begin
                    $display("%0t: last_word mismatch: expected %b, actual %b",
                             $time, exp_word.last, m_axis_tlast);
                    failed = 1'b1;
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            absorb_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            items_taken <= items_taken + 1;
        end
    end

    // Watchdog: too long without a transfer on either side ends the run.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sha1_hash_engine verification failed");
            $finish;
        end
    end

    initial
    begin
        // Directed part: the empty message, the end riding on a byte, the end
        // on its own after an ignored transfer, a short text and two empty
        // messages back to back.
        push_item(8'ha5, 1'b0, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b1, 1'b0);
        push_item(8'hff, 1'b1, 1'b0, 1'b0);
        push_item(8'h5a, 1'b0, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1, 1'b0);
        push_item(8'h61, 1'b1, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0, 1'b0);
        push_item(8'h63, 1'b1, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b1, 1'b0);
        push_item(8'h3c, 1'b0, 1'b1, 1'b0);

        // Random part. The first message waits for the directed digests to
        // drain completely; later ones do so now and then.
        counted_items = 0;
        queue_message(pick_length(), 1'b1);
        while (counted_items < RANDOM_ITEMS)
            queue_message(pick_length(), $urandom_range(0, 9) == 0);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        while (items_taken != items_queued)
            @(posedge clk);
        while (digest_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (!failed && digest_expect.size() == 0)
            $display("sha1_hash_engine verification clean");
        else
            $display("sha1_hash_engine verification failed");
        $finish;
    end
endmodule
